[src/pff_pkg.sv]
// Types and constants shared by the Pareto front filter modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pff_pkg;

   localparam int COST_W  = 32;
   localparam int ENTRY_W = 2 * COST_W;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_CLEAR,
      OP_EVAL,
      OP_INSERT,
      OP_REPLACE,
      OP_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic [COST_W-1:0]  second_cost;
      logic [COST_W-1:0]  third_cost;
   } cell_ctrl_type;

   typedef struct packed {
      logic drop;
      logic any_remove;
      logic full;
   } chain_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DECIDE,
      ST_SHIFT
   } state_type;

   localparam logic [1:0] OBJ_THREE = 2'd3;
   localparam logic [1:0] OBJ_RESET = 2'd2;

endpackage

`default_nettype wire

[src/pff_cell.sv]
// One staircase cell: holds a (second, third) entry and its compare flags.
// Depends on pff_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pff_cell (
   input  wire                     clock,
   input  wire                     reset,
   input  wire pff_pkg::cell_ctrl_type ctrl,
   input  wire [pff_pkg::ENTRY_W-1:0] left_entry,
   input  wire                     left_valid,
   input  wire                     left_gt,
   input  wire [pff_pkg::ENTRY_W-1:0] right_entry,
   input  wire                     right_valid,
   input  wire                     right_gt,
   input  wire                     right_rm,
   output logic [pff_pkg::ENTRY_W-1:0] entry,
   output logic                    valid,
   output logic                    gt,
   output logic                    rm,
   output logic                    tle
);
   import pff_pkg::*;

   logic [ENTRY_W-1:0] entry_ff, entry_in;
   logic               valid_ff, valid_in;
   logic               gt_ff, gt_in;
   logic               rm_ff, rm_in;
   logic               tle_ff, tle_in;
   logic [ENTRY_W-1:0] item;
   logic               le;

   assign item = {ctrl.second_cost, ctrl.third_cost};
   assign le   = valid_ff && (entry_ff <= item);

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      gt_in    = gt_ff;
      rm_in    = rm_ff;
      tle_in   = tle_ff;
      case (ctrl.op)
         OP_CLEAR: begin
            valid_in = 1'b0;
         end
         OP_EVAL: begin
            gt_in  = !le;
            rm_in  = valid_ff && !le && (entry_ff[COST_W-1:0] >= ctrl.third_cost);
            tle_in = le && (entry_ff[COST_W-1:0] <= ctrl.third_cost);
         end
         OP_INSERT: begin
            if (gt_ff) begin
               if (left_gt) begin
                  entry_in = left_entry;
                  valid_in = left_valid;
               end else begin
                  entry_in = item;
                  valid_in = 1'b1;
               end
            end
         end
         OP_REPLACE: begin
            if (gt_ff && !left_gt) begin
               entry_in = item;
               valid_in = 1'b1;
               gt_in    = 1'b0;
               rm_in    = 1'b0;
            end
         end
         OP_SHIFT: begin
            if (gt_ff) begin
               entry_in = right_entry;
               valid_in = right_valid;
               gt_in    = right_gt;
               rm_in    = right_rm;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         gt_ff    <= 1'b0;
         rm_ff    <= 1'b0;
         tle_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         gt_ff    <= gt_in;
         rm_ff    <= rm_in;
         tle_ff   <= tle_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign valid = valid_ff;
   assign gt    = gt_ff;
   assign rm    = rm_ff;
   assign tle   = tle_ff;

endmodule

`default_nettype wire

[src/pff_chain.sv]
// Row of staircase cells with neighbor links and the status reductions.
// Depends on pff_pkg and pff_cell.
`timescale 1ns / 1ps
`default_nettype none

module pff_chain #(
   parameter int STAIR_DEPTH = 64
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire pff_pkg::cell_ctrl_type ctrl,
   output pff_pkg::chain_status_type status
);
   import pff_pkg::*;

   logic [ENTRY_W-1:0]     entry [STAIR_DEPTH];
   logic [STAIR_DEPTH-1:0] valid;
   logic [STAIR_DEPTH-1:0] gt;
   logic [STAIR_DEPTH-1:0] rm;
   logic [STAIR_DEPTH-1:0] tle;

   for (genvar i = 0; i < STAIR_DEPTH; i++) begin : g_cell
      logic [ENTRY_W-1:0] l_entry, r_entry;
      logic               l_valid, l_gt, r_valid, r_gt, r_rm;

      if (i == 0) begin : g_first
         assign l_entry = '0;
         assign l_valid = 1'b0;
         assign l_gt    = 1'b0;
      end else begin : g_mid_l
         assign l_entry = entry[i-1];
         assign l_valid = valid[i-1];
         assign l_gt    = gt[i-1];
      end

      if (i == STAIR_DEPTH - 1) begin : g_last
         assign r_entry = '0;
         assign r_valid = 1'b0;
         assign r_gt    = 1'b1;
         assign r_rm    = 1'b0;
      end else begin : g_mid_r
         assign r_entry = entry[i+1];
         assign r_valid = valid[i+1];
         assign r_gt    = gt[i+1];
         assign r_rm    = rm[i+1];
      end

      pff_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_entry  (l_entry),
         .left_valid  (l_valid),
         .left_gt     (l_gt),
         .right_entry (r_entry),
         .right_valid (r_valid),
         .right_gt    (r_gt),
         .right_rm    (r_rm),
         .entry       (entry[i]),
         .valid       (valid[i]),
         .gt          (gt[i]),
         .rm          (rm[i]),
         .tle         (tle[i])
      );
   end

   // drop, any_remove, full
   assign status = {|tle, |rm, valid[STAIR_DEPTH-1]};

endmodule

`default_nettype wire

[src/pareto_front_filter.sv]
// Top level of the Pareto front filter: control sequencer, running minimum,
// mode register and result register. Depends on pff_pkg and pff_chain.
`timescale 1ns / 1ps
`default_nettype none

// Judges one item at a time. The cells compare the item in the EVAL state and
// the result is registered when the DECIDE state loads the output register,
// later while the previous result still waits there. In three-objective mode
// an item that removes staircase entries then passes through the SHIFT state:
// the first removed entry is overwritten in place, each further one moves the
// tail one cell per cycle, and a final SHIFT step with no remove ends the pass.
// The sequencer broadcasts each step to the whole row of cells. The next item
// is taken as soon as the sequencer is idle, even while the last result still
// waits in the output register.
module pareto_front_filter #(
   parameter int STAIR_DEPTH = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [63:0] req_tdata,   // second_cost[31:0], third_cost[63:32]
   input  wire  [0:0]  req_tuser,   // list_start[0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // keep[0], zero fill [7:1]
   output logic [0:0]  rsp_tuser,   // overflow[0]
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_data     // objective_count
);
   import pff_pkg::*;

   state_type          state_ff, state_in;
   logic [1:0]         obj_ff;
   logic [COST_W-1:0]  second_ff, third_ff;
   logic [COST_W-1:0]  min_ff, min_in;
   logic               min_valid_ff, min_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               keep_ff, keep_in;
   logic               ovf_ff, ovf_in;
   logic               load;
   logic               accept;
   logic               out_busy;
   cell_ctrl_type      ctrl;
   chain_status_type   status;

   assign accept    = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign out_busy  = rsp_valid_ff && !rsp_tready;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in         = state_ff;
      ctrl.op          = OP_HOLD;
      ctrl.second_cost = second_ff;
      ctrl.third_cost  = third_ff;
      load             = 1'b0;
      keep_in          = keep_ff;
      ovf_in           = ovf_ff;
      min_in           = min_ff;
      min_valid_in     = min_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EVAL;
               if (req_tuser[0]) begin
                  ctrl.op      = OP_CLEAR;
                  min_in       = '1;
                  min_valid_in = 1'b0;
               end
            end
         end
         ST_EVAL: begin
            ctrl.op  = OP_EVAL;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!out_busy) begin
               load     = 1'b1;
               state_in = ST_IDLE;
               ovf_in   = 1'b0;
               if (obj_ff == OBJ_THREE) begin
                  keep_in = !status.drop;
                  if (!status.drop) begin
                     if (status.any_remove) begin
                        ctrl.op  = OP_REPLACE;
                        state_in = ST_SHIFT;
                     end else if (status.full) begin
                        ovf_in = 1'b1;
                     end else begin
                        ctrl.op = OP_INSERT;
                     end
                  end
               end else begin
                  keep_in = !min_valid_ff || (second_ff < min_ff);
                  if (keep_in) begin
                     min_in       = second_ff;
                     min_valid_in = 1'b1;
                  end
               end
            end
         end
         ST_SHIFT: begin
            if (status.any_remove) begin
               ctrl.op = OP_SHIFT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_busy || load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         obj_ff       <= OBJ_RESET;
         min_ff       <= '1;
         min_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_ff       <= min_in;
         min_valid_ff <= min_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            obj_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      keep_ff <= keep_in;
      ovf_ff  <= ovf_in;
      if (accept) begin
         second_ff <= req_tdata[COST_W-1:0];
         third_ff  <= req_tdata[2*COST_W-1:COST_W];
      end
   end

   pff_chain #(
      .STAIR_DEPTH (STAIR_DEPTH)
   ) u_chain (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .status (status)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, keep_ff};
   assign rsp_tuser  = ovf_ff;

endmodule

`default_nettype wire

[tb/sv/pareto_front_filter_test.sv]
// Self-checking testbench for pareto_front_filter: streams cost vectors through the
// filter in two- and three-objective mode and checks every keep/overflow result.
// Depends on pff_pkg and the pareto_front_filter RTL.
`timescale 1ns / 1ps

module pareto_front_filter_test;
   import pff_pkg::*;

   localparam int STAIR_DEPTH    = 64;
   localparam int ITEM_TARGET    = 1400;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 100;
   localparam int IDLE_PCT       = 30;
   localparam int CALM_FROM      = 500;
   localparam int CALM_TO        = 800;
   localparam int HOLD_CYCLES    = 400;

   // register values other than three that select two-objective filtering
   localparam logic [1:0] OBJ_COUNT_0 = 2'd0;
   localparam logic [1:0] OBJ_COUNT_1 = 2'd1;

   typedef struct {
      bit                start;
      logic [COST_W-1:0] second;
      logic [COST_W-1:0] third;
   } candidate_type;

   typedef struct {
      bit keep;
      bit overflow;
   } verdict_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;   // second_cost[31:0], third_cost[63:32]
   logic [0:0]  req_tuser  = '0;   // list_start[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // keep[0], zero fill [7:1]
   logic [0:0]  rsp_tuser;         // overflow[0]
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_data   = OBJ_RESET;

   pareto_front_filter #(
      .STAIR_DEPTH(STAIR_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   candidate_type pending_q[$];
   verdict_type   verdict_q[$];
   candidate_type next_cand;

   int   items_queued  = 0;
   int   items_taken   = 0;
   int   results_seen  = 0;
   int   error_count   = 0;
   int   quiet_cycles  = 0;
   int   hold_left     = 0;
   int   next_hold_at  = 300;
   logic req_fire      = 1'b0;
   logic csr_fire      = 1'b0;

   logic [1:0] mode_plan [8] = '{OBJ_THREE, OBJ_RESET, OBJ_THREE, OBJ_COUNT_0,
                                 OBJ_THREE, OBJ_COUNT_1, OBJ_RESET, OBJ_THREE};

   // filter state as the block should hold it
   logic [ENTRY_W-1:0] stair_entry [STAIR_DEPTH];
   int                 stair_len  = 0;
   logic [COST_W-1:0]  cost_floor = '1;
   bit                 floor_set  = 1'b0;
   logic [1:0]         obj_mode   = OBJ_RESET;

   function automatic verdict_type judge_candidate(input bit start,
                                                   input logic [COST_W-1:0] second,
                                                   input logic [COST_W-1:0] third);
      verdict_type        r;
      logic [ENTRY_W-1:0] key;
      int                 lo;
      int                 hi;
      int                 tail;
      int                 k;
      r.keep     = 1'b0;
      r.overflow = 1'b0;
      key        = {second, third};
      if (start) begin
         stair_len = 0;
         cost_floor = '1;
         floor_set = 1'b0;
      end
      if (obj_mode != OBJ_THREE) begin
         if (!floor_set || second < cost_floor) begin
            cost_floor = second;
            floor_set  = 1'b1;
            r.keep     = 1'b1;
         end
         return r;
      end
      lo = 0;
      while (lo < stair_len && stair_entry[lo] <= key) lo++;
      if (lo > 0 && stair_entry[lo-1][COST_W-1:0] <= third) return r;
      hi = lo;
      while (hi < stair_len && stair_entry[hi][COST_W-1:0] >= third) hi++;
      r.keep = 1'b1;
      if (hi == lo && stair_len >= STAIR_DEPTH) begin
         r.overflow = 1'b1;
         return r;
      end
      tail = stair_len - hi;
      if (hi == lo) begin
         for (k = tail - 1; k >= 0; k--) stair_entry[lo+1+k] = stair_entry[hi+k];
      end else begin
         for (k = 0; k < tail; k++) stair_entry[lo+1+k] = stair_entry[hi+k];
      end
      stair_entry[lo] = key;
      stair_len = lo + 1 + tail;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR %0t ns: %s", $time, msg);
      error_count++;
   endtask

   function automatic bit roll_idle();
      if (items_taken >= CALM_FROM && items_taken < CALM_TO) return 1'b0;
      return $urandom_range(99) < IDLE_PCT;
   endfunction

   // sampling at the rising edge: predict on accept, check on result
   always @(posedge clock) begin
      verdict_type want;
      if (!reset) begin
         req_fire <= req_tvalid && req_tready;
         csr_fire <= csr_valid && csr_ready;
         if (req_tvalid && req_tready) begin
            verdict_q.insert(verdict_q.size(),
                             judge_candidate(req_tuser[0], req_tdata[31:0],
                                             req_tdata[63:32]));
            items_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (verdict_q.size() == 0) begin
               report_mismatch($sformatf("result %0d with no item pending", results_seen));
            end else begin
               want = verdict_q[0];
               verdict_q.delete(0);
               if (rsp_tdata !== {7'b0, want.keep})
                  report_mismatch($sformatf("result %0d: keep byte %h, expected %h",
                                            results_seen, rsp_tdata, {7'b0, want.keep}));
               if (rsp_tuser !== want.overflow)
                  report_mismatch($sformatf("result %0d: overflow %b, expected %b",
                                            results_seen, rsp_tuser, want.overflow));
            end
         end
         if (csr_valid && csr_ready) obj_mode = csr_data;
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
   end

   // item driver
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_fire)) begin
         if (pending_q.size() > 0 && !roll_idle()) begin
            next_cand = pending_q[0];
            pending_q.delete(0);
            req_tvalid <= 1'b1;
            req_tdata  <= {next_cand.third, next_cand.second};
            req_tuser  <= next_cand.start;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result receiver, with long hold-offs while items keep coming
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (results_seen >= next_hold_at && pending_q.size() > 20) begin
         rsp_tready   <= 1'b0;
         hold_left    <= HOLD_CYCLES;
         next_hold_at <= next_hold_at + 800;
      end else begin
         rsp_tready <= !roll_idle();
      end
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(negedge clock);
      $display("simulation failed");
      $finish;
   end

   task automatic add_item(input bit start, input logic [COST_W-1:0] second,
                           input logic [COST_W-1:0] third);
      candidate_type c;
      c.start  = start;
      c.second = second;
      c.third  = third;
      pending_q.insert(pending_q.size(), c);
      items_queued++;
   endtask

   task automatic drain();
      while (pending_q.size() != 0 || req_tvalid || verdict_q.size() != 0) @(negedge clock);
   endtask

   task automatic write_mode(input logic [1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(negedge clock); while (!csr_fire);
      csr_valid <= 1'b0;
   endtask

   task automatic add_random_list();
      int                kind;
      int                len;
      int                span;
      int                i;
      logic [COST_W-1:0] s;
      logic [COST_W-1:0] t;
      kind = $urandom_range(99);
      if (kind < 30) begin
         // narrow values: ties, duplicates, near dominance
         len  = $urandom_range(1, 30);
         span = (kind < 15) ? 15 : 255;
         for (i = 0; i < len; i++)
            add_item(i == 0, $urandom_range(span), $urandom_range(span));
      end else if (kind < 55) begin
         // fill the staircase, often past full, then sweep most of it away
         len  = $urandom_range(60, 72);
         span = $urandom_range(1, 1000);
         s    = $urandom_range(1000, 100000);
         t    = 32'hFFFF_0000 - $urandom_range(0, 1000);
         add_item(1'b1, s, t);
         for (i = 1; i < len; i++) begin
            s = s + span;
            t = t - span;
            add_item(1'b0, s, t);
            if ($urandom_range(99) < 15)
               add_item(1'b0, s + $urandom_range(0, 2), t + $urandom_range(0, 2 * span));
         end
         add_item(1'b0, s - $urandom_range(0, len * span), $urandom_range(0, 16));
      end else if (kind < 70) begin
         // falling second cost: long keep chains in two-objective mode
         len = $urandom_range(2, 40);
         s   = $urandom;
         for (i = 0; i < len; i++) begin
            add_item(i == 0, s, $urandom_range(255));
            s = s - $urandom_range(0, 3);
         end
      end else if (kind < 85) begin
         len = $urandom_range(1, 8);
         for (i = 0; i < len; i++) add_item(i == 0, $urandom, $urandom);
      end else begin
         // continue the current list, rare stray start marker
         len = $urandom_range(1, 10);
         for (i = 0; i < len; i++)
            add_item($urandom_range(9) == 0, $urandom_range(255), $urandom_range(255));
      end
   endtask

   initial begin
      int phase;
      int budget;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // two-objective mode from reset: first item, equal and all-ones costs
      add_item(1'b1, 32'h8000_0000, '0);
      add_item(1'b0, '1, '1);
      add_item(1'b0, '0, '1);
      add_item(1'b0, '0, '0);
      add_item(1'b1, '1, '0);
      add_item(1'b0, '1, 32'h5);
      drain();
      write_mode(OBJ_THREE);
      // empty staircase, duplicate, dominated, append, front insert, multi remove
      add_item(1'b0, 5, 5);
      add_item(1'b0, 5, 5);
      add_item(1'b0, 6, 6);
      add_item(1'b0, 6, 4);
      add_item(1'b0, 4, 9);
      add_item(1'b0, 4, 0);
      add_item(1'b0, '0, '1);
      add_item(1'b0, '1, '1);
      add_item(1'b0, '1, '0);
      add_item(1'b1, '1, '1);
      add_item(1'b0, '0, '0);
      // mode switches inside one list keep each mode's state
      drain();
      write_mode(OBJ_RESET);
      add_item(1'b0, 7, 0);
      add_item(1'b0, 7, 0);
      drain();
      write_mode(OBJ_THREE);
      add_item(1'b0, 0, 0);

      phase = 0;
      while (items_queued < ITEM_TARGET) begin
         drain();
         write_mode(mode_plan[phase % 8]);
         budget = items_queued + $urandom_range(60, 200);
         while (items_queued < budget) add_random_list();
         phase++;
      end

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (verdict_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", verdict_q.size()));
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
